@@ rtl/core/crs_pkg.sv @@
// package for the concentric ring energy sum: payload types, register codes, constants
`timescale 1ns / 1ps
`default_nettype none
package crs_pkg;

  localparam int SAMPLING_KINDS = 32;

  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 32;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_RING_COUNT    = 3'd0,
    CFG_ETA_STEP      = 3'd1,
    CFG_PHI_STEP      = 3'd2,
    CFG_SAMPLING_MASK = 3'd3
  } crs_cfg_idx_t;

  localparam logic [6:0]  RING_COUNT_RST    = 7'd64;
  localparam logic [12:0] ETA_STEP_RST      = 13'd102;
  localparam logic [12:0] PHI_STEP_RST      = 13'd402;
  localparam logic [31:0] SAMPLING_MASK_RST = 32'hFFFF_FFFF;

  // Q3.12 angle constants
  localparam logic [14:0] Q_ONE     = 15'd4096;
  localparam logic [14:0] Q_PI      = 15'd12868;
  localparam logic [14:0] Q_WRAP_HI = 15'd21639;
  localparam logic signed [17:0] Q_TWO_PI = 18'sd25736;

  localparam int SUM_W = 40;
  localparam int DIFF_W = 17;
  localparam int NUM_W = 19;
  localparam int DEN_W = 14;

  typedef struct packed {
    logic signed [15:0] cell_eta;
    logic [14:0]        cell_phi;
    logic signed [23:0] cell_energy;
    logic [4:0]         cell_sampling;
    logic signed [15:0] centre_eta;
    logic [14:0]        centre_phi;
  } crs_cell_t;

  typedef struct packed {
    logic                    hit;
    logic [5:0]              ring_index;
    logic signed [SUM_W-1:0] ring_sum;
  } crs_ring_t;

endpackage
`default_nettype wire

@@ rtl/core/concentric_ring_energy_sum_top.sv @@
// top level of the concentric ring energy sum: cell prep, ring search, ring sum memory
//
//  channel | dir | handshake               | payload
//  cell    | in  | cell_valid / cell_stall | cell_req (crs_cell_t)
//  sum     | out | sum_valid / sum_stall   | sum_rsp  (crs_ring_t)
//  cfg     | in  | cfg_valid / cfg_ready   | cfg_index, cfg_data
//
// one cell per cycle while cell_stall is low; a result passes the prep register,
// the one-bit-per-stage ring divider (RW = clog2(MAX_RINGS)), the add and output registers
// ring sums sit in a memory read in the cycle before the add, with one-deep
// forwarding of the previous write; valid bits clear the sums at reset at once
// a stalled result parks in a skid register; cell_stall rises only while it is full
`timescale 1ns / 1ps
`default_nettype none
module concentric_ring_energy_sum_top #(
  parameter int MAX_RINGS = 64
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         cell_valid,
  output logic                              cell_stall,
  input  wire crs_pkg::crs_cell_t           cell_req,
  output logic                              sum_valid,
  input  wire logic                         sum_stall,
  output crs_pkg::crs_ring_t                sum_rsp,
  input  wire logic                         cfg_valid,
  output logic                              cfg_ready,
  input  wire logic [crs_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [crs_pkg::CFG_DATA_W-1:0] cfg_data
);
  import crs_pkg::*;

  localparam int RW = (MAX_RINGS > 1) ? $clog2(MAX_RINGS) : 1;
  localparam logic [8:0] MAX_R9 = 9'(MAX_RINGS);
  localparam logic signed [SUM_W:0] SUM_MAX = {2'b00, {(SUM_W-1){1'b1}}};
  localparam logic signed [SUM_W:0] SUM_MIN = {2'b11, {(SUM_W-1){1'b0}}};

  // configuration
  logic [6:0]  ring_count;
  logic [12:0] eta_step;
  logic [12:0] phi_step;
  logic [31:0] sampling_mask;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      ring_count    <= RING_COUNT_RST;
      eta_step      <= ETA_STEP_RST;
      phi_step      <= PHI_STEP_RST;
      sampling_mask <= SAMPLING_MASK_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_RING_COUNT:    ring_count    <= cfg_data[6:0];
        CFG_ETA_STEP:      eta_step      <= cfg_data[12:0];
        CFG_PHI_STEP:      phi_step      <= cfg_data[12:0];
        CFG_SAMPLING_MASK: sampling_mask <= cfg_data;
        default: ;
      endcase
    end
  end

  // pipeline enable
  logic skid_valid;
  logic en;
  assign en = !skid_valid;
  assign cell_stall = skid_valid;

  // cell prep
  logic signed [17:0] eta_diff;
  logic signed [17:0] phi_adj;
  logic signed [17:0] phi_use;
  logic signed [17:0] phi_diff;
  logic [DIFF_W-1:0]  eta_abs;
  logic [DIFF_W-1:0]  phi_abs;
  logic               cell_on;

  always_comb begin
    eta_diff = {{2{cell_req.cell_eta[15]}}, cell_req.cell_eta}
             - {{2{cell_req.centre_eta[15]}}, cell_req.centre_eta};
    phi_adj = '0;
    if (cell_req.centre_phi > Q_WRAP_HI && cell_req.cell_phi < Q_PI) begin
      phi_adj = Q_TWO_PI;
    end else if (cell_req.centre_phi < Q_ONE && cell_req.cell_phi >= Q_PI) begin
      phi_adj = -Q_TWO_PI;
    end
    phi_use  = $signed({3'b000, cell_req.cell_phi}) + phi_adj;
    phi_diff = phi_use - $signed({3'b000, cell_req.centre_phi});
    eta_abs  = eta_diff[17] ? DIFF_W'(-eta_diff) : DIFF_W'(eta_diff);
    phi_abs  = phi_diff[17] ? DIFF_W'(-phi_diff) : DIFF_W'(phi_diff);
    cell_on  = (32'(cell_req.cell_sampling) < 32'(SAMPLING_KINDS))
             && sampling_mask[cell_req.cell_sampling];
  end

  logic               p_valid;
  logic               p_on;
  logic [DIFF_W-1:0]  p_eta_abs;
  logic [DIFF_W-1:0]  p_phi_abs;
  logic signed [23:0] p_energy;

  always_ff @(posedge clk) begin
    if (rst) begin
      p_valid <= 1'b0;
    end else if (en) begin
      p_valid <= cell_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p_on      <= cell_on;
      p_eta_abs <= eta_abs;
      p_phi_abs <= phi_abs;
      p_energy  <= cell_req.cell_energy;
    end
  end

  // ring search: smallest ring = floor((2d + step) / (2 step)) per dimension
  logic [NUM_W-1:0] eta_num;
  logic [NUM_W-1:0] phi_num;
  logic [DEN_W-1:0] eta_den;
  logic [DEN_W-1:0] phi_den;
  logic [RW-1:0]    eta_q;
  logic [RW-1:0]    phi_q;
  logic             eta_ovf;
  logic             phi_ovf;

  assign eta_num = NUM_W'({p_eta_abs, 1'b0}) + NUM_W'(eta_step);
  assign phi_num = NUM_W'({p_phi_abs, 1'b0}) + NUM_W'(phi_step);
  assign eta_den = {eta_step, 1'b0};
  assign phi_den = {phi_step, 1'b0};

  crs_div #(.QW(RW)) u_eta_div (
    .clk (clk),
    .en  (en),
    .num (eta_num),
    .den (eta_den),
    .quo (eta_q),
    .ovf (eta_ovf)
  );

  crs_div #(.QW(RW)) u_phi_div (
    .clk (clk),
    .en  (en),
    .num (phi_num),
    .den (phi_den),
    .quo (phi_q),
    .ovf (phi_ovf)
  );

  logic               sb_valid  [0:RW];
  logic               sb_on     [0:RW];
  logic signed [23:0] sb_energy [0:RW];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int j = 0; j <= RW; j++) begin
        sb_valid[j] <= 1'b0;
      end
    end else if (en) begin
      sb_valid[0] <= p_valid;
      for (int j = 1; j <= RW; j++) begin
        sb_valid[j] <= sb_valid[j-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sb_on[0]     <= p_on;
      sb_energy[0] <= p_energy;
      for (int j = 1; j <= RW; j++) begin
        sb_on[j]     <= sb_on[j-1];
        sb_energy[j] <= sb_energy[j-1];
      end
    end
  end

  // ring select
  logic [8:0]    rings;
  logic [RW-1:0] ring_q;
  logic          sel_hit;
  logic [RW-1:0] sel_idx;

  always_comb begin
    rings   = (9'(ring_count) > MAX_R9) ? MAX_R9 : 9'(ring_count);
    ring_q  = (eta_q > phi_q) ? eta_q : phi_q;
    sel_hit = sb_on[RW] && !eta_ovf && !phi_ovf && (9'(ring_q) < rings);
    sel_idx = sel_hit ? ring_q : '0;
  end

  // ring sum memory
  logic [SUM_W-1:0] ring_mem [0:MAX_RINGS-1];
  logic             ring_vld [0:MAX_RINGS-1];
  logic [SUM_W-1:0] rd_data;
  logic             rd_vld;

  logic               a_valid;
  logic               a_hit;
  logic [RW-1:0]      a_idx;
  logic signed [23:0] a_energy;

  logic               lw_valid;
  logic [RW-1:0]      lw_idx;
  logic [SUM_W-1:0]   lw_sum;

  logic signed [SUM_W-1:0] base;
  logic signed [SUM_W:0]   sum_raw;
  logic signed [SUM_W-1:0] sum_sat;
  logic                    a_write;
  crs_ring_t               res;

  always_comb begin
    if (lw_valid && lw_idx == a_idx) begin
      base = lw_sum;
    end else if (rd_vld) begin
      base = rd_data;
    end else begin
      base = '0;
    end
    sum_raw = {base[SUM_W-1], base} + {{(SUM_W-23){a_energy[23]}}, a_energy};
    if (sum_raw > SUM_MAX) begin
      sum_sat = SUM_MAX[SUM_W-1:0];
    end else if (sum_raw < SUM_MIN) begin
      sum_sat = SUM_MIN[SUM_W-1:0];
    end else begin
      sum_sat = sum_raw[SUM_W-1:0];
    end
    a_write = en && a_valid && a_hit;
    res.hit        = a_hit;
    res.ring_index = a_hit ? 6'(a_idx) : '0;
    res.ring_sum   = a_hit ? sum_sat : '0;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rd_data <= ring_mem[sel_idx];
    end
    if (a_write) begin
      ring_mem[a_idx] <= sum_sat;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int r = 0; r < MAX_RINGS; r++) begin
        ring_vld[r] <= 1'b0;
      end
      rd_vld <= 1'b0;
    end else begin
      if (en) begin
        rd_vld <= ring_vld[sel_idx];
      end
      if (a_write) begin
        ring_vld[a_idx] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid  <= 1'b0;
      lw_valid <= 1'b0;
    end else if (en) begin
      a_valid  <= sb_valid[RW];
      lw_valid <= a_valid && a_hit;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_hit    <= sel_hit;
      a_idx    <= sel_idx;
      a_energy <= sb_energy[RW];
      lw_idx   <= a_idx;
      lw_sum   <= sum_sat;
    end
  end

  // output register with skid
  crs_ring_t skid;
  logic      new_valid;
  assign new_valid = en && a_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      sum_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!sum_valid || !sum_stall) begin
      if (skid_valid) begin
        sum_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        sum_valid <= new_valid;
      end
    end else if (new_valid) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!sum_valid || !sum_stall) begin
      sum_rsp <= skid_valid ? skid : res;
    end else if (new_valid) begin
      skid <= res;
    end
  end

endmodule
`default_nettype wire

@@ rtl/core/crs_div.sv @@
// pipelined restoring divider giving a ring quotient and an overflow flag, one bit per stage
`timescale 1ns / 1ps
`default_nettype none
module crs_div #(
  parameter int QW = 6
) (
  input  wire logic                       clk,
  input  wire logic                       en,
  input  wire logic [crs_pkg::NUM_W-1:0]  num,
  input  wire logic [crs_pkg::DEN_W-1:0]  den,
  output logic [QW-1:0]                   quo,
  output logic                            ovf
);
  import crs_pkg::*;

  localparam int DVW = NUM_W + QW;

  logic [DVW-1:0] rem_s [0:QW];
  logic [DVW-1:0] den_s [0:QW];
  logic           ovf_s [0:QW];
  logic [QW-1:0]  q_s   [0:QW];

  logic [DVW-1:0] num_x;
  logic [DVW-1:0] den_x;

  assign num_x = DVW'(num);
  assign den_x = DVW'(den);

  always_ff @(posedge clk) begin
    if (en) begin
      rem_s[0] <= num_x;
      den_s[0] <= den_x;
      ovf_s[0] <= (num_x >= (den_x << QW));
      q_s[0]   <= '0;
    end
  end

  for (genvar j = 1; j <= QW; j++) begin : g_stage
    localparam int K = QW - j;
    logic [DVW-1:0] trial;
    logic           take;
    assign trial = den_s[j-1] << K;
    assign take  = (rem_s[j-1] >= trial);
    always_ff @(posedge clk) begin
      if (en) begin
        rem_s[j] <= take ? (rem_s[j-1] - trial) : rem_s[j-1];
        den_s[j] <= den_s[j-1];
        ovf_s[j] <= ovf_s[j-1];
        q_s[j]   <= (q_s[j-1] << 1) | QW'(take);
      end
    end
  end

  assign quo = q_s[QW];
  assign ovf = ovf_s[QW];

endmodule
`default_nettype wire

@@ rtl/core/crs_checker.sv @@
// port-level checks on the concentric ring energy sum top, with its bind
`timescale 1ns / 1ps
`default_nettype none
module crs_checker (
  input wire logic                           clk,
  input wire logic                           rst,
  input wire logic                           cell_valid,
  input wire logic                           cell_stall,
  input wire crs_pkg::crs_cell_t             cell_req,
  input wire logic                           sum_valid,
  input wire logic                           sum_stall,
  input wire crs_pkg::crs_ring_t             sum_rsp,
  input wire logic                           cfg_valid,
  input wire logic                           cfg_ready,
  input wire logic [crs_pkg::CFG_IDX_W-1:0]  cfg_index,
  input wire logic [crs_pkg::CFG_DATA_W-1:0] cfg_data
);
  import crs_pkg::*;

  // reset leaves no result and no back-pressure
  a_reset_clear: assert property (@(posedge clk)
    rst |=> !sum_valid && !cell_stall)
    else $error("result or stall active after reset");

  // a miss carries a zero ring and a zero sum
  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    sum_valid && !sum_rsp.hit |-> sum_rsp.ring_index == 6'd0 && sum_rsp.ring_sum == '0)
    else $error("miss with nonzero ring or sum");

  // cells are refused only while a result is held back
  a_stall_needs_result: assert property (@(posedge clk) disable iff (rst)
    cell_stall |-> sum_valid)
    else $error("cell stall with no pending result");

  // back-pressure starts only after the consumer stalled
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    $rose(cell_stall) |-> $past(sum_valid && sum_stall))
    else $error("cell stall without a stalled result");

  // a stalled result holds
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    sum_valid && sum_stall |=> sum_valid && $stable(sum_rsp))
    else $error("stalled result changed");

endmodule

bind concentric_ring_energy_sum_top crs_checker u_crs_checker (.*);
`default_nettype wire
